@@ rtl/pat_pkg.sv @@
package pat_pkg;

   // Pool geometry
   localparam int ENTRIES     = 16;
   localparam int MAX_RESULTS = 16;
   localparam int ADDR_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int IDX_W       = $clog2(ENTRIES + 1);   // one extra code for null
   localparam int STEP_LIMIT  = (ENTRIES > MAX_RESULTS) ? ENTRIES : MAX_RESULTS;
   localparam int CNT_W       = $clog2(STEP_LIMIT + 1);
   localparam int POS_W       = 4;
   localparam int PTR_W       = 64;

   localparam logic [IDX_W-1:0] NIL = IDX_W'(ENTRIES);

   // Operation codes
   localparam logic [1:0] OP_RECORD  = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_LIST    = 2'd2;

   // Status codes
   localparam logic [2:0] ST_RECORDED  = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_RELEASED  = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_NULL      = 3'd4;
   localparam logic [2:0] ST_LISTED    = 3'd5;
   localparam logic [2:0] ST_EMPTY     = 3'd6;

   typedef struct packed {
      logic [1:0]       operation;
      logic [PTR_W-1:0] pointer_value;
   } pat_req_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [PTR_W-1:0] listed_pointer;
      logic [POS_W-1:0] list_position;
      logic             last;
   } pat_rsp_type;

   // Link update command from the sequencer to the entry store
   typedef struct packed {
      logic             rec;   // take target off free list, push on in-use list
      logic             rel;   // unlink target from in-use list, push on free list
      logic [IDX_W-1:0] prev;  // in-use predecessor of target (NIL if head)
      logic [IDX_W-1:0] tgt;   // entry being moved
      logic [PTR_W-1:0] ptr;   // pointer stored on record
   } pat_upd_type;

endpackage

@@ rtl/pat_store.sv @@
module pat_store (
   input  logic                     clock,
   input  logic                     reset,
   input  pat_pkg::pat_upd_type     upd,
   input  logic [pat_pkg::IDX_W-1:0] rd_idx,
   output logic [pat_pkg::PTR_W-1:0] rd_ptr,
   output logic [pat_pkg::IDX_W-1:0] rd_next,
   output logic [pat_pkg::IDX_W-1:0] free_head,
   output logic [pat_pkg::IDX_W-1:0] used_head
);
   import pat_pkg::*;

   logic [PTR_W-1:0] ptr_mem_ff [ENTRIES];
   logic [IDX_W-1:0] next_ff    [ENTRIES];
   logic [IDX_W-1:0] free_head_ff;
   logic [IDX_W-1:0] used_head_ff;
   logic             rd_ok;
   logic             prev_ok;

   assign rd_ok   = (rd_idx < NIL);
   assign prev_ok = (upd.prev < NIL);

   // single read port, shared by record (free head) and walk (current entry)
   assign rd_ptr  = rd_ok ? ptr_mem_ff[rd_idx[ADDR_W-1:0]] : '0;
   assign rd_next = rd_ok ? next_ff[rd_idx[ADDR_W-1:0]]    : NIL;

   assign free_head = free_head_ff;
   assign used_head = used_head_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            next_ff[i] <= IDX_W'(i + 1);
         end
         free_head_ff <= '0;
         used_head_ff <= NIL;
      end else begin
         if (upd.rec) begin
            free_head_ff                  <= rd_next;
            next_ff[upd.tgt[ADDR_W-1:0]]  <= used_head_ff;
            used_head_ff                  <= upd.tgt;
         end
         if (upd.rel) begin
            if (prev_ok) begin
               next_ff[upd.prev[ADDR_W-1:0]] <= rd_next;
            end else begin
               used_head_ff <= rd_next;
            end
            next_ff[upd.tgt[ADDR_W-1:0]] <= free_head_ff;
            free_head_ff                 <= upd.tgt;
         end
      end
   end

   // pointer payload, no reset
   always_ff @(posedge clock) begin
      if (upd.rec) begin
         ptr_mem_ff[upd.tgt[ADDR_W-1:0]] <= upd.ptr;
      end
   end

endmodule

@@ rtl/pointer_allocation_tracker.sv @@
// Pointer allocation tracker: a pool of ENTRIES (16) entries, each on either the
// free list or the in-use list. A record transaction is accepted from idle, then
// updates the lists and returns RECORDED (or FULL) once the output register is
// free. A release walks the in-use list newest first, one entry per cycle through
// a single 64-bit comparator, and relinks when the RELEASED result enters the
// output register. A list transaction returns one result per cycle while the
// output is not stalled, newest first, at most 16, the final one flagged last; an
// empty pool gives a single EMPTY result. The block takes no new request while a
// transaction is in progress; results sit in an output register, so a stalled
// result only holds the sequencer when the next result is ready. Operation code 3
// is accepted and produces nothing.
module pointer_allocation_tracker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  pat_pkg::pat_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pat_pkg::pat_rsp_type rsp_payload
);
   import pat_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_RECORD,
      S_RELEASE,
      S_LIST
   } state_type;

   state_type        state_ff, state_in;
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic [IDX_W-1:0] cur_ff, cur_in;
   logic [IDX_W-1:0] prev_ff, prev_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   pat_rsp_type      rsp_payload_ff, rsp_payload_in;

   pat_upd_type      upd;
   logic [IDX_W-1:0] rd_idx;
   logic [PTR_W-1:0] rd_ptr;
   logic [IDX_W-1:0] rd_next;
   logic [IDX_W-1:0] free_head;
   logic [IDX_W-1:0] used_head;

   logic             slot_free;
   logic             cur_valid;
   logic             hit;
   logic             emit;
   pat_rsp_type      emit_rsp;

   pat_store u_store (
      .clock     (clock),
      .reset     (reset),
      .upd       (upd),
      .rd_idx    (rd_idx),
      .rd_ptr    (rd_ptr),
      .rd_next   (rd_next),
      .free_head (free_head),
      .used_head (used_head)
   );

   // output register can take a new result this cycle
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);

   // record reads the free head, release and list read the walk cursor
   assign rd_idx    = (state_ff == S_RECORD) ? free_head : cur_ff;
   assign cur_valid = (cur_ff < NIL);

   // the shared comparator
   assign hit = (rd_ptr == ptr_ff);

   always_comb begin
      state_in = state_ff;
      ptr_in   = ptr_ff;
      cur_in   = cur_ff;
      prev_in  = prev_ff;
      count_in = count_ff;
      upd      = '0;
      upd.prev = prev_ff;
      upd.tgt  = rd_idx;
      upd.ptr  = ptr_ff;
      emit     = 1'b0;
      emit_rsp = '0;
      emit_rsp.last = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ptr_in   = req_payload.pointer_value;
               cur_in   = used_head;
               prev_in  = NIL;
               count_in = '0;
               case (req_payload.operation)
                  OP_RECORD:  state_in = S_RECORD;
                  OP_RELEASE: state_in = S_RELEASE;
                  OP_LIST:    state_in = S_LIST;
                  default:    state_in = S_IDLE;
               endcase
            end
         end

         S_RECORD: begin
            if (slot_free) begin
               emit = 1'b1;
               if (free_head < NIL) begin
                  upd.rec         = 1'b1;
                  emit_rsp.status = ST_RECORDED;
               end else begin
                  emit_rsp.status = ST_FULL;
               end
               state_in = S_IDLE;
            end
         end

         S_RELEASE: begin
            if (ptr_ff == '0) begin
               if (slot_free) begin
                  emit            = 1'b1;
                  emit_rsp.status = ST_NULL;
                  state_in        = S_IDLE;
               end
            end else if (!cur_valid || count_ff == CNT_W'(ENTRIES)) begin
               if (slot_free) begin
                  emit            = 1'b1;
                  emit_rsp.status = ST_NOT_FOUND;
                  state_in        = S_IDLE;
               end
            end else if (hit) begin
               // unlink and free in the same cycle as the result goes out
               if (slot_free) begin
                  upd.rel         = 1'b1;
                  emit            = 1'b1;
                  emit_rsp.status = ST_RELEASED;
                  state_in        = S_IDLE;
               end
            end else begin
               prev_in  = cur_ff;
               cur_in   = rd_next;
               count_in = count_ff + 1'b1;
            end
         end

         S_LIST: begin
            if (slot_free) begin
               emit = 1'b1;
               if (!cur_valid) begin
                  emit_rsp.status = ST_EMPTY;
                  state_in        = S_IDLE;
               end else begin
                  emit_rsp.status         = ST_LISTED;
                  emit_rsp.listed_pointer = rd_ptr;
                  emit_rsp.list_position  = count_ff[POS_W-1:0];
                  emit_rsp.last           = !(rd_next < NIL) ||
                                            (count_ff == CNT_W'(MAX_RESULTS - 1));
                  cur_in   = rd_next;
                  count_in = count_ff + 1'b1;
                  if (emit_rsp.last) begin
                     state_in = S_IDLE;
                  end
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in   = slot_free ? emit : rsp_valid_ff;
      rsp_payload_in = (slot_free && emit) ? emit_rsp : rsp_payload_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff         <= ptr_in;
      cur_ff         <= cur_in;
      prev_ff        <= prev_in;
      count_ff       <= count_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
